// ===== rtl/bal_pkg.sv =====
// ----------------------------------------------------------------------------
// bal_pkg: shared types and codes for the bounded array list
// Command, error and field width definitions used by the interfaces,
// the sequencer and the top level.
// ----------------------------------------------------------------------------
package bal_pkg;

   // Fixed field widths of the item channels
   localparam int CMD_W   = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 7;
   localparam int ERR_W   = 2;
   localparam int IDX_W   = 8;
   localparam int COUNT_W = 8;
   localparam int CAP_W   = 8;

   typedef logic [CMD_W-1:0]          cmd_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [POS_W-1:0]          pos_type;
   typedef logic [ERR_W-1:0]          err_type;
   typedef logic signed [IDX_W-1:0]   idx_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [CAP_W-1:0]          cap_type;

   // Command codes
   localparam cmd_type CMD_PUSH_END   = 3'd0;
   localparam cmd_type CMD_PUSH_FRONT = 3'd1;
   localparam cmd_type CMD_POP_END    = 3'd2;
   localparam cmd_type CMD_POP_FRONT  = 3'd3;
   localparam cmd_type CMD_REMOVE_AT  = 3'd4;
   localparam cmd_type CMD_FIND       = 3'd5;
   localparam cmd_type CMD_QUERY      = 3'd6;

   // Error codes
   localparam err_type ERR_NONE  = 2'd0;
   localparam err_type ERR_FULL  = 2'd1;
   localparam err_type ERR_EMPTY = 2'd2;
   localparam err_type ERR_RANGE = 2'd3;

   // Index reported when no entry matches
   localparam idx_type IDX_NONE = -8'sd1;

   // Capacity after reset
   localparam cap_type CAP_RESET = 8'd100;

endpackage

// ===== rtl/bal_if.sv =====
// ----------------------------------------------------------------------------
// bal_if: channel interfaces of the bounded array list
// Command channel, result channel and capacity write channel, each a
// valid/ready handshake with a source and a sink modport.
// ----------------------------------------------------------------------------
interface bal_req_if;
   logic              valid;
   logic              ready;
   bal_pkg::cmd_type   cmd;
   bal_pkg::value_type value;
   bal_pkg::pos_type   position;

   modport source (output valid, output cmd, output value, output position, input ready);
   modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

interface bal_rsp_if;
   logic               valid;
   logic               ready;
   bal_pkg::err_type    error;
   bal_pkg::idx_type    found_index;
   bal_pkg::value_type  first_value;
   bal_pkg::value_type  last_value;
   bal_pkg::count_type  count;
   logic               is_empty;

   modport source (output valid, output error, output found_index, output first_value,
                   output last_value, output count, output is_empty, input ready);
   modport sink   (input valid, input error, input found_index, input first_value,
                   input last_value, input count, input is_empty, output ready);
endinterface

interface bal_csr_if;
   logic             valid;
   logic             ready;
   bal_pkg::cap_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bal_ram.sv =====
// ----------------------------------------------------------------------------
// bal_ram: entry store of the bounded array list
// Simple dual-port synchronous RAM, one write and one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module bal_ram #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [DATA_WIDTH-1:0]     wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [DATA_WIDTH-1:0]     rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bal_seq.sv =====
// ----------------------------------------------------------------------------
// bal_seq: command sequencer of the bounded array list
// Decodes one command, walks the entry RAM for shifts and searches, reads
// back the first and last entries and loads the result register.
// ----------------------------------------------------------------------------
module bal_seq #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bal_pkg::cap_type          capacity,
   bal_req_if.sink                   req_bus,
   bal_rsp_if.source                 rsp_bus,
   output logic                      mem_we,
   output logic [$clog2(DEPTH)-1:0]  mem_wa,
   output logic [DATA_WIDTH-1:0]     mem_wd,
   output logic                      mem_re,
   output logic [$clog2(DEPTH)-1:0]  mem_ra,
   input  logic [DATA_WIDTH-1:0]     mem_rd
);
   import bal_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = (FW > CAP_W) ? FW : CAP_W;
   localparam int PW = (FW > POS_W) ? FW : POS_W;

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SHUP     = 4'd1;
   localparam logic [3:0] S_SHDN     = 4'd2;
   localparam logic [3:0] S_TAIL     = 4'd3;
   localparam logic [3:0] S_WFRONT   = 4'd4;
   localparam logic [3:0] S_FIND     = 4'd5;
   localparam logic [3:0] S_RD_FIRST = 4'd6;
   localparam logic [3:0] S_RD_LAST  = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   logic [3:0]            state_ff,     state_in;
   logic [FW-1:0]         fill_ff,      fill_in;
   logic [FW-1:0]         ptr_ff,       ptr_in;
   logic                  wv_ff,        wv_in;
   logic [AW-1:0]         wa_ff,        wa_in;
   logic                  cmp_v_ff,     cmp_v_in;
   logic [FW-1:0]         cmp_idx_ff,   cmp_idx_in;
   cmd_type               cmd_ff,       cmd_in;
   logic [DATA_WIDTH-1:0] key_ff,       key_in;
   err_type               err_ff,       err_in;
   idx_type               found_ff,     found_in;
   logic [VALUE_W-1:0]    first_ff,     first_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   err_type               rsp_err_ff,   rsp_err_in;
   idx_type               rsp_found_ff, rsp_found_in;
   logic [VALUE_W-1:0]    rsp_first_ff, rsp_first_in;
   logic [VALUE_W-1:0]    rsp_last_ff,  rsp_last_in;
   count_type             rsp_count_ff, rsp_count_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic                  req_fire;
   logic                  full;
   logic                  empty;
   logic [PW-1:0]         from_pos;
   logic [FW-1:0]         fill_m1;
   logic [63:0]           value_ext;
   logic [63:0]           rd_ext;
   logic [VALUE_W-1:0]    rd_low;
   logic                  hit;
   logic                  out_free;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // list status and operand shaping
   assign full      = (CW'(fill_ff) >= CW'(capacity)) || (fill_ff == FW'(DEPTH));
   assign empty     = (fill_ff == '0);
   assign fill_m1   = fill_ff - FW'(1);
   assign from_pos  = (req_bus.cmd == CMD_POP_FRONT) ? '0 : PW'(req_bus.position);
   assign value_ext = {32'b0, req_bus.value};
   assign rd_ext    = 64'(mem_rd);
   assign rd_low    = rd_ext[VALUE_W-1:0];
   assign hit       = cmp_v_ff && (mem_rd == key_ff);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      wv_in        = wv_ff;
      wa_in        = wa_ff;
      cmp_v_in     = cmp_v_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      err_in       = err_ff;
      found_in     = found_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_err_in   = rsp_err_ff;
      rsp_found_in = rsp_found_ff;
      rsp_first_in = rsp_first_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      rsp_empty_in = rsp_empty_ff;
      mem_we       = 1'b0;
      mem_wa       = wa_ff;
      mem_wd       = mem_rd;
      mem_re       = 1'b0;
      mem_ra       = ptr_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_bus.cmd;
               key_in   = value_ext[DATA_WIDTH-1:0];
               err_in   = ERR_NONE;
               found_in = IDX_NONE;
               wv_in    = 1'b0;
               cmp_v_in = 1'b0;
               state_in = S_RD_FIRST;
               case (req_bus.cmd) inside
                  CMD_PUSH_END: begin
                     if (full) begin
                        err_in = ERR_FULL;
                     end else begin
                        mem_we  = 1'b1;
                        mem_wa  = fill_ff[AW-1:0];
                        mem_wd  = value_ext[DATA_WIDTH-1:0];
                        fill_in = fill_ff + FW'(1);
                     end
                  end
                  CMD_PUSH_FRONT: begin
                     if (full) begin
                        err_in = ERR_FULL;
                     end else if (empty) begin
                        state_in = S_WFRONT;
                     end else begin
                        ptr_in   = fill_m1;
                        state_in = S_SHUP;
                     end
                  end
                  CMD_POP_END: begin
                     if (empty) begin
                        err_in = ERR_EMPTY;
                     end else begin
                        fill_in = fill_m1;
                     end
                  end
                  CMD_POP_FRONT, CMD_REMOVE_AT: begin
                     if (empty) begin
                        err_in = ERR_EMPTY;
                     end else if (from_pos >= PW'(fill_ff)) begin
                        err_in = ERR_RANGE;
                     end else if (from_pos == PW'(fill_m1)) begin
                        fill_in = fill_m1;
                     end else begin
                        ptr_in   = FW'(from_pos + PW'(1));
                        state_in = S_SHDN;
                     end
                  end
                  CMD_FIND: begin
                     ptr_in   = '0;
                     state_in = S_FIND;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // shift up: read downward, write each entry one place higher
         S_SHUP: begin
            mem_we = wv_ff;
            mem_re = 1'b1;
            wv_in  = 1'b1;
            wa_in  = AW'(ptr_ff + FW'(1));
            if (ptr_ff == '0) begin
               state_in = S_TAIL;
            end else begin
               ptr_in = ptr_ff - FW'(1);
            end
         end

         // shift down: read upward, write each entry one place lower
         S_SHDN: begin
            mem_we = wv_ff;
            mem_re = 1'b1;
            wv_in  = 1'b1;
            wa_in  = AW'(ptr_ff - FW'(1));
            if (ptr_ff == fill_m1) begin
               state_in = S_TAIL;
            end else begin
               ptr_in = ptr_ff + FW'(1);
            end
         end

         // drain the last pending shift write
         S_TAIL: begin
            mem_we = wv_ff;
            wv_in  = 1'b0;
            if (cmd_ff == CMD_PUSH_FRONT) begin
               state_in = S_WFRONT;
            end else begin
               fill_in  = fill_m1;
               state_in = S_RD_FIRST;
            end
         end

         S_WFRONT: begin
            mem_we   = 1'b1;
            mem_wa   = '0;
            mem_wd   = key_ff;
            fill_in  = fill_ff + FW'(1);
            state_in = S_RD_FIRST;
         end

         // linear search, each compare comes in the cycle after its read
         S_FIND: begin
            if (hit) begin
               found_in = IDX_W'(cmp_idx_ff);
               cmp_v_in = 1'b0;
               state_in = S_RD_FIRST;
            end else if (ptr_ff < fill_ff) begin
               mem_re     = 1'b1;
               cmp_v_in   = 1'b1;
               cmp_idx_in = ptr_ff;
               ptr_in     = ptr_ff + FW'(1);
            end else begin
               cmp_v_in = 1'b0;
               state_in = S_RD_FIRST;
            end
         end

         S_RD_FIRST: begin
            mem_re   = 1'b1;
            mem_ra   = '0;
            state_in = S_RD_LAST;
         end

         S_RD_LAST: begin
            first_in = rd_low;
            mem_re   = 1'b1;
            mem_ra   = fill_m1[AW-1:0];
            state_in = S_DONE;
         end

         // load the result register once it is free
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_found_in = found_ff;
               rsp_first_in = empty ? '0 : first_ff;
               rsp_last_in  = empty ? '0 : rd_low;
               rsp_count_in = COUNT_W'(fill_ff);
               rsp_empty_in = empty;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         wv_ff        <= 1'b0;
         cmp_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         wv_ff        <= wv_in;
         cmp_v_ff     <= cmp_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      wa_ff        <= wa_in;
      cmp_idx_ff   <= cmp_idx_in;
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      err_ff       <= err_in;
      found_ff     <= found_in;
      first_ff     <= first_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_found_ff <= rsp_found_in;
      rsp_first_ff <= rsp_first_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.error       = rsp_err_ff;
   assign rsp_bus.found_index = rsp_found_ff;
   assign rsp_bus.first_value = rsp_first_ff;
   assign rsp_bus.last_value  = rsp_last_ff;
   assign rsp_bus.count       = rsp_count_ff;
   assign rsp_bus.is_empty    = rsp_empty_ff;

   // fill never exceeds the store
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(DEPTH))
      else $error("fill above storage depth");

   // fill moves by at most one per cycle
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && fill_ff != $past(fill_ff)) |->
      ((FW+1)'(fill_ff) == (FW+1)'($past(fill_ff)) + (FW+1)'(1) ||
       (FW+1)'(fill_ff) + (FW+1)'(1) == (FW+1)'($past(fill_ff))))
      else $error("fill jumped by more than one");

   // a shift never writes the entry it reads in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_wa != mem_ra))
      else $error("read and write of the same entry");

   // a result appears only out of the final state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == S_DONE))
      else $error("result loaded outside final state");

endmodule

// ===== rtl/bounded_array_list.sv =====
// ----------------------------------------------------------------------------
// bounded_array_list: ordered list of signed values in a RAM
// Top level: capacity register, command sequencer and entry store.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  carries one command item (cmd, value, position); rsp_bus returns
//   one result item per command (error, found_index, first/last value, count,
//   is_empty). csr_bus writes the capacity register; it is always ready and
//   should only be written while no command is in flight.
// Every command ends by reading back the first and last entries and
// loading the result register, from which rsp_bus takes the result:
//   push front shifts every entry up one place, then writes the front entry.
//   remove at position p shifts the entries above p down one place, unless
//   p is the last entry; pop front is remove at position 0.
//   find compares the entries in order and stops on the first hit.
//   The shifts and the search walk the entry RAM through its single read
//   port, one entry per cycle.
// One command is worked at a time; req_bus is ready whenever the sequencer
// is idle, even while a result still waits in the output register.
// Reset empties the list and sets capacity to 100; the RAM is not cleared.
// When rsp_bus stalls, the next command runs up to its result and then
// waits until the held result is taken.
// ----------------------------------------------------------------------------
module bounded_array_list #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   bal_req_if.sink   req_bus,
   bal_rsp_if.source rsp_bus,
   bal_csr_if.sink   csr_bus
);
   import bal_pkg::*;

   localparam int AW = $clog2(DEPTH);

   cap_type               capacity_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_wa;
   logic [DATA_WIDTH-1:0] mem_wd;
   logic                  mem_re;
   logic [AW-1:0]         mem_ra;
   logic [DATA_WIDTH-1:0] mem_rd;

   // capacity register
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         capacity_ff <= csr_bus.data;
      end
   end

   bal_seq #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .capacity (capacity_ff),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .mem_we   (mem_we),
      .mem_wa   (mem_wa),
      .mem_wd   (mem_wd),
      .mem_re   (mem_re),
      .mem_ra   (mem_ra),
      .mem_rd   (mem_rd)
   );

   bal_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

endmodule
